// ----- sv/blca_pkg.sv -----
package blca_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 11;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 16;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam int ALU_OP_W = 2;
    localparam logic [ALU_OP_W-1:0] ALU_EQ     = 2'd0;
    localparam logic [ALU_OP_W-1:0] ALU_GE     = 2'd1;
    localparam logic [ALU_OP_W-1:0] ALU_GE_LVL = 2'd2;

endpackage

// ----- sv/blca_alu.sv -----
module blca_alu
    import blca_pkg::*;
#(
    parameter int  LEVELS = 10,
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic [ALU_OP_W-1:0] i_op,
    input  logic [NODE_W-1:0]   i_x,
    input  logic [NODE_W-1:0]   i_y,
    input  logic [LW-1:0]       i_lvl,
    output logic                o_flag
);

    // wide enough for a depth plus the largest lift step
    localparam int SW = ((LEVELS > NODE_W) ? LEVELS : NODE_W) + 1;

    logic [SW-1:0] w_sum;

    assign w_sum = SW'(i_y) + (SW'(1) << i_lvl);

    always_comb begin
        unique case (i_op)
            ALU_EQ:     o_flag = (i_x == i_y);
            ALU_GE:     o_flag = (i_x >= i_y);
            ALU_GE_LVL: o_flag = (SW'(i_x) >= w_sum);
            default:    o_flag = 1'b0;
        endcase
    end

endmodule

// ----- sv/blca_store.sv -----
module blca_store
    import blca_pkg::*;
#(
    parameter int  MAX_NODES = 1024,
    parameter int  LEVELS    = 10,
    localparam int AW        = $clog2(MAX_NODES),
    localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_anc_we,
    input  logic [LW-1:0]      i_anc_wlvl,
    input  logic [AW-1:0]      i_anc_waddr,
    input  logic [NODE_W-1:0]  i_anc_wdata,
    input  logic [LW-1:0]      i_anc_rlvl,
    input  logic [AW-1:0]      i_anc_raddr,
    input  logic               i_anc_rok,
    output logic [NODE_W-1:0]  o_anc_rdata,
    input  logic               i_dep_we,
    input  logic [AW-1:0]      i_dep_waddr,
    input  logic [DEPTH_W-1:0] i_dep_wdata,
    input  logic [AW-1:0]      i_dep_raddr,
    input  logic               i_dep_rok,
    output logic [DEPTH_W-1:0] o_dep_rdata
);

    // ancestor table addressed as {level, node}
    logic [NODE_W-1:0]  r_anc_mem [2**(LW+AW)];
    logic [DEPTH_W-1:0] r_dep_mem [2**AW];

    logic [NODE_W-1:0]  r_anc_q;
    logic [DEPTH_W-1:0] r_dep_q;
    logic               r_anc_ok;
    logic               r_dep_ok;

    always_ff @(posedge i_clk) begin
        if (i_anc_we) begin
            r_anc_mem[{i_anc_wlvl, i_anc_waddr}] <= i_anc_wdata;
        end
        r_anc_q  <= r_anc_mem[{i_anc_rlvl, i_anc_raddr}];
        r_anc_ok <= i_anc_rok;
    end

    always_ff @(posedge i_clk) begin
        if (i_dep_we) begin
            r_dep_mem[i_dep_waddr] <= i_dep_wdata;
        end
        r_dep_q  <= r_dep_mem[i_dep_raddr];
        r_dep_ok <= i_dep_rok;
    end

    // nodes beyond the table read as zero
    assign o_anc_rdata = r_anc_ok ? r_anc_q : '0;
    assign o_dep_rdata = r_dep_ok ? r_dep_q : '0;

endmodule

// ----- sv/binary_lifting_lca_unit.sv -----
// Channel   Dir  Transfer            Contents
// s         in   tvalid & tready     tdata: node_index, parent_node, node_depth_in, other_node
//                                    tuser: mode
// m         out  tvalid & tready     tdata: ancestor_node; tuser: is_answer
// cfg       in   i_cfg_we            node_count
//
// One item at a time; o_s_tready is high only while the sequencer is idle.
// Load writes a node's parent and depth and an unused mode goes straight to the finish;
// a query steps through every level on the lift and, unless the nodes meet, on the climb,
// paced by the single read port of each memory; build fills levels 1 to LEVELS-1 for
// min(node_count,MAX_NODES) nodes, one entry at a time. The next transfer is taken in the
// cycle after the result register loads; a full output register stalls only the finish.
// Synchronous active-low reset clears control state only; memories are not cleared.
module binary_lifting_lca_unit
    import blca_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,   // node_index, parent_node, node_depth_in, other_node
    input  logic [MODE_W-1:0] i_s_tuser,   // mode
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // ancestor_node, zero pad
    output logic              o_m_tuser,   // is_answer
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int MCW = $clog2(MAX_NODES + 1);
    localparam int CW  = (MCW > CNT_W) ? MCW : CNT_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOAD  = 5'd1;
    localparam logic [4:0] S_QDA   = 5'd2;
    localparam logic [4:0] S_QDB   = 5'd3;
    localparam logic [4:0] S_QSW   = 5'd4;
    localparam logic [4:0] S_LCHK  = 5'd5;
    localparam logic [4:0] S_LANC  = 5'd6;
    localparam logic [4:0] S_LDEP  = 5'd7;
    localparam logic [4:0] S_MEET  = 5'd8;
    localparam logic [4:0] S_CRA   = 5'd9;
    localparam logic [4:0] S_CRB   = 5'd10;
    localparam logic [4:0] S_CCMP  = 5'd11;
    localparam logic [4:0] S_FRD   = 5'd12;
    localparam logic [4:0] S_FIN   = 5'd13;
    localparam logic [4:0] S_BINIT = 5'd14;
    localparam logic [4:0] S_BRD1  = 5'd15;
    localparam logic [4:0] S_BRD2  = 5'd16;
    localparam logic [4:0] S_BWR   = 5'd17;
    localparam logic [4:0] S_DONE  = 5'd18;

    function automatic logic f_in_range(input logic [NODE_W-1:0] n);
        return (32'(n) < MAX_NODES);
    endfunction

    // control
    logic [4:0]         r_state,      n_state;
    logic [LW-1:0]      r_lvl,        n_lvl;
    logic [CW-1:0]      r_cnt,        n_cnt;
    logic [CW-1:0]      r_bcount,     n_bcount;
    logic [CNT_W-1:0]   r_node_count;
    logic               r_out_valid,  n_out_valid;
    // payload
    logic [MODE_W-1:0]  r_mode,       n_mode;
    logic [NODE_W-1:0]  r_a,          n_a;
    logic [NODE_W-1:0]  r_b,          n_b;
    logic [NODE_W-1:0]  r_par,        n_par;
    logic [DEPTH_W-1:0] r_dep,        n_dep;
    logic [DEPTH_W-1:0] r_da,         n_da;
    logic [DEPTH_W-1:0] r_db,         n_db;
    logic [NODE_W-1:0]  r_ua,         n_ua;
    logic [NODE_W-1:0]  r_res,        n_res;
    logic               r_out_ans,    n_out_ans;
    logic [NODE_W-1:0]  r_out_node,   n_out_node;

    logic               anc_we;
    logic [LW-1:0]      anc_wlvl;
    logic [AW-1:0]      anc_waddr;
    logic [NODE_W-1:0]  anc_wdata;
    logic [LW-1:0]      anc_rlvl;
    logic [AW-1:0]      anc_raddr;
    logic               anc_rok;
    logic [NODE_W-1:0]  anc_rdata;
    logic               dep_we;
    logic [AW-1:0]      dep_raddr;
    logic               dep_rok;
    logic [DEPTH_W-1:0] dep_rdata;

    logic [ALU_OP_W-1:0] alu_op;
    logic [NODE_W-1:0]   alu_x;
    logic [NODE_W-1:0]   alu_y;
    logic                alu_flag;

    logic [CW-1:0] w_count;

    assign w_count = (CW'(r_node_count) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                          : CW'(r_node_count);

    blca_store #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_store (
        .i_clk       (i_clk),
        .i_anc_we    (anc_we),
        .i_anc_wlvl  (anc_wlvl),
        .i_anc_waddr (anc_waddr),
        .i_anc_wdata (anc_wdata),
        .i_anc_rlvl  (anc_rlvl),
        .i_anc_raddr (anc_raddr),
        .i_anc_rok   (anc_rok),
        .o_anc_rdata (anc_rdata),
        .i_dep_we    (dep_we),
        .i_dep_waddr (AW'(r_a)),
        .i_dep_wdata (r_dep),
        .i_dep_raddr (dep_raddr),
        .i_dep_rok   (dep_rok),
        .o_dep_rdata (dep_rdata)
    );

    blca_alu #(
        .LEVELS (LEVELS)
    ) u_alu (
        .i_op   (alu_op),
        .i_x    (alu_x),
        .i_y    (alu_y),
        .i_lvl  (r_lvl),
        .o_flag (alu_flag)
    );

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_cnt       = r_cnt;
        n_bcount    = r_bcount;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_a         = r_a;
        n_b         = r_b;
        n_par       = r_par;
        n_dep       = r_dep;
        n_da        = r_da;
        n_db        = r_db;
        n_ua        = r_ua;
        n_res       = r_res;
        n_out_ans   = r_out_ans;
        n_out_node  = r_out_node;

        anc_we    = 1'b0;
        anc_wlvl  = '0;
        anc_waddr = AW'(r_cnt);
        anc_wdata = anc_rdata;
        anc_rlvl  = r_lvl;
        anc_raddr = AW'(r_a);
        anc_rok   = f_in_range(r_a);
        dep_we    = 1'b0;
        dep_raddr = AW'(r_a);
        dep_rok   = f_in_range(r_a);
        alu_op    = ALU_EQ;
        alu_x     = r_a;
        alu_y     = r_b;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_mode = i_s_tuser;
                    n_a    = i_s_tdata[NODE_W-1:0];
                    n_par  = i_s_tdata[2*NODE_W-1:NODE_W];
                    n_dep  = i_s_tdata[2*NODE_W+DEPTH_W-1:2*NODE_W];
                    n_b    = i_s_tdata[IN_W-1:IN_W-NODE_W];
                    n_res  = '0;
                    unique case (i_s_tuser)
                        MODE_LOAD:  n_state = S_LOAD;
                        MODE_BUILD: n_state = S_BINIT;
                        MODE_QUERY: n_state = S_QDA;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                anc_we    = f_in_range(r_a);
                anc_waddr = AW'(r_a);
                anc_wdata = r_par;
                dep_we    = f_in_range(r_a);
                n_state   = S_DONE;
            end
            S_QDA: begin
                n_state = S_QDB;
            end
            S_QDB: begin
                dep_raddr = AW'(r_b);
                dep_rok   = f_in_range(r_b);
                n_da      = dep_rdata;
                n_state   = S_QSW;
            end
            S_QSW: begin
                // keep the deeper node in a
                alu_op = ALU_GE;
                alu_x  = r_da;
                alu_y  = dep_rdata;
                if (alu_flag) begin
                    n_db = dep_rdata;
                end else begin
                    n_a  = r_b;
                    n_b  = r_a;
                    n_da = dep_rdata;
                    n_db = r_da;
                end
                n_lvl   = LW'(LEVELS - 1);
                n_state = S_LCHK;
            end
            S_LCHK: begin
                alu_op = ALU_GE_LVL;
                alu_x  = r_da;
                alu_y  = r_db;
                if (alu_flag) begin
                    n_state = S_LANC;
                end else if (r_lvl == '0) begin
                    n_state = S_MEET;
                end else begin
                    n_lvl = LW'(r_lvl - 1'b1);
                end
            end
            S_LANC: begin
                n_a       = anc_rdata;
                dep_raddr = AW'(anc_rdata);
                dep_rok   = f_in_range(anc_rdata);
                n_state   = S_LDEP;
            end
            S_LDEP: begin
                n_da = dep_rdata;
                if (r_lvl == '0) begin
                    n_state = S_MEET;
                end else begin
                    n_lvl   = LW'(r_lvl - 1'b1);
                    n_state = S_LCHK;
                end
            end
            S_MEET: begin
                alu_op = ALU_EQ;
                if (alu_flag) begin
                    n_res   = r_a;
                    n_state = S_DONE;
                end else begin
                    n_lvl   = LW'(LEVELS - 1);
                    n_state = S_CRA;
                end
            end
            S_CRA: begin
                n_state = S_CRB;
            end
            S_CRB: begin
                n_ua      = anc_rdata;
                anc_raddr = AW'(r_b);
                anc_rok   = f_in_range(r_b);
                n_state   = S_CCMP;
            end
            S_CCMP: begin
                alu_op = ALU_EQ;
                alu_x  = r_ua;
                alu_y  = anc_rdata;
                if (!alu_flag) begin
                    n_a = r_ua;
                    n_b = anc_rdata;
                end
                if (r_lvl == '0) begin
                    n_state = S_FRD;
                end else begin
                    n_lvl   = LW'(r_lvl - 1'b1);
                    n_state = S_CRA;
                end
            end
            S_FRD: begin
                anc_rlvl = '0;
                n_state  = S_FIN;
            end
            S_FIN: begin
                n_res   = anc_rdata;
                n_state = S_DONE;
            end
            S_BINIT: begin
                n_bcount = w_count;
                n_cnt    = '0;
                n_lvl    = '0;
                if (w_count == '0 || LEVELS == 1) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_BRD1;
                end
            end
            S_BRD1: begin
                anc_raddr = AW'(r_cnt);
                anc_rok   = 1'b1;
                n_state   = S_BRD2;
            end
            S_BRD2: begin
                // ancestor of the ancestor, same level
                anc_raddr = AW'(anc_rdata);
                anc_rok   = f_in_range(anc_rdata);
                n_state   = S_BWR;
            end
            S_BWR: begin
                anc_we    = 1'b1;
                anc_wlvl  = LW'(r_lvl + 1'b1);
                anc_waddr = AW'(r_cnt);
                anc_wdata = anc_rdata;
                n_state   = S_BRD1;
                if (CW'(r_cnt + 1'b1) == r_bcount) begin
                    n_cnt = '0;
                    if (r_lvl == LW'(LEVELS - 2)) begin
                        n_state = S_DONE;
                    end else begin
                        n_lvl = LW'(r_lvl + 1'b1);
                    end
                end else begin
                    n_cnt = CW'(r_cnt + 1'b1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ans   = (r_mode == MODE_QUERY);
                    n_out_node  = (r_mode == MODE_QUERY) ? r_res : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lvl        <= '0;
            r_cnt        <= '0;
            r_bcount     <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_cnt       <= n_cnt;
            r_bcount    <= n_bcount;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_a        <= n_a;
        r_b        <= n_b;
        r_par      <= n_par;
        r_dep      <= n_dep;
        r_da       <= n_da;
        r_db       <= n_db;
        r_ua       <= n_ua;
        r_res      <= n_res;
        r_out_ans  <= n_out_ans;
        r_out_node <= n_out_node;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_ans;
    assign o_m_tdata  = {{(OUT_W-NODE_W){1'b0}}, r_out_node};

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("acknowledgement carries a non-zero node");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_s_tvalid) |=> (r_state == S_IDLE))
        else $error("sequencer left idle without a transfer");

    a_build_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWR) |-> (r_cnt < r_bcount))
        else $error("build node counter beyond node count");

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= LW'(LEVELS - 1))
        else $error("level counter out of range");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_tready) |=> (r_state == S_DONE))
        else $error("result dropped while output register full");

endmodule
